>>> rtl/lidar_point_projection_top_assert.svh
// Assertion macros for the lidar point projection block.
// Define NO_ASSERTIONS to compile them out.
`ifndef LIDAR_POINT_PROJECTION_TOP_ASSERT_SVH
`define LIDAR_POINT_PROJECTION_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LPP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LPP_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> expr) else $error(msg);
`else
`define LPP_ASSERT(label, prop, msg)
`define LPP_ASSERT_NEXT(label, cond, expr, msg)
`endif
`endif

>>> rtl/lpp_pkg.sv
// Shared types and constants for the lidar point projection block.
// No dependencies.
package lpp_pkg;
    localparam int CoordW = 24;
    localparam int CoefW  = 21;
    localparam int CfgW   = 63;
    localparam int AccW   = 48;
    localparam int PixW   = 16;
    localparam int QuotW  = 17;
    localparam int Stages = 20;

    localparam logic signed [CoordW-1:0] XMinRaw = 24'sd52;
    localparam logic signed [CoordW-1:0] RampCentre = 24'sd3840;

    typedef enum logic [2:0] {
        REG_ROW_U  = 3'd0,
        REG_ROW_V  = 3'd1,
        REG_ROW_W  = 3'd2,
        REG_OFFSET = 3'd3,
        REG_MAX_X  = 3'd4,
        REG_MAX_Y  = 3'd5,
        REG_MIN_Z  = 3'd6,
        REG_NONE   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic signed [CoordW-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [PixW-1:0]   pixel_u;
        logic signed [PixW-1:0]   pixel_v;
        logic                     pixel_invalid;
        logic signed [CoordW-1:0] echo_x;
        logic signed [CoordW-1:0] echo_y;
        logic [7:0]               red_level;
        logic [7:0]               green_level;
    } pixel_t;

    typedef struct packed {
        logic [CfgW-1:0]        row_u;
        logic [CfgW-1:0]        row_v;
        logic [CfgW-1:0]        row_w;
        logic [CfgW-1:0]        offset;
        logic [22:0]            max_x;
        logic [22:0]            max_y;
        logic signed [CoordW-1:0] min_z;
    } cfg_t;
endpackage

>>> rtl/lpp_if.sv
// Valid/ready channel interfaces: points, pixels and register writes.
// Depends on lpp_pkg.
interface lpp_point_if;
    import lpp_pkg::*;
    logic   valid;
    logic   ready;
    point_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lpp_pixel_if;
    import lpp_pkg::*;
    logic   valid;
    logic   ready;
    pixel_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lpp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/lidar_point_projection_top.sv
// One point per cycle while no pixel beat is held by the sink.
// A pixel beat held by the sink freezes the whole pipeline and drops input ready.
// u/v division: 17-stage restoring divider, a range test then one quotient bit a stage.
// Dropped points leave a bubble and give no beat.
// rst_n clears the pipeline valid bits and loads the register reset values.
// Depends on lpp_pkg, lpp_if, lpp_regs and lpp_pipe.
module lidar_point_projection_top (
    input  logic        clk,
    input  logic        rst_n,
    lpp_point_if.sink   points,
    lpp_pixel_if.source pixels,
    lpp_cfg_if.sink     cfg
);
    import lpp_pkg::*;

    cfg_t regs;

    lpp_regs u_regs (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg),
        .regs (regs)
    );

    lpp_pipe u_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .regs     (regs),
        .in_valid (points.valid),
        .in_data  (points.data),
        .in_ready (points.ready),
        .out_valid(pixels.valid),
        .out_data (pixels.data),
        .out_ready(pixels.ready)
    );
endmodule

>>> rtl/lpp_regs.sv
// Configuration register file.
// Depends on lpp_pkg and lpp_if.
module lpp_regs (
    input  logic         clk,
    input  logic         rst_n,
    lpp_cfg_if.sink      cfg,
    output lpp_pkg::cfg_t regs
);
    import lpp_pkg::*;

    cfg_t regs_reg;
    reg_idx_t idx;

    assign cfg.ready = 1'b1;
    assign regs = regs_reg;
    assign idx = reg_idx_t'(cfg.index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.row_u  <= '0;
            regs_reg.row_v  <= '0;
            regs_reg.row_w  <= '0;
            regs_reg.offset <= '0;
            regs_reg.max_x  <= '1;
            regs_reg.max_y  <= '1;
            regs_reg.min_z  <= {1'b1, {(CoordW-1){1'b0}}};
        end
        else if (cfg.valid)
        begin
            unique case (idx)
                REG_ROW_U:  regs_reg.row_u  <= cfg.wdata[CfgW-1:0];
                REG_ROW_V:  regs_reg.row_v  <= cfg.wdata[CfgW-1:0];
                REG_ROW_W:  regs_reg.row_w  <= cfg.wdata[CfgW-1:0];
                REG_OFFSET: regs_reg.offset <= cfg.wdata[CfgW-1:0];
                REG_MAX_X:  regs_reg.max_x  <= cfg.wdata[22:0];
                REG_MAX_Y:  regs_reg.max_y  <= cfg.wdata[22:0];
                REG_MIN_Z:  regs_reg.min_z  <= cfg.wdata[CoordW-1:0];
                default:    ;
            endcase
        end
    end
endmodule

>>> rtl/lpp_divider.sv
// One restoring-division stage: one quotient bit per stage.
// Depends on lpp_pkg.
module lpp_div_stage (
    input  logic [lpp_pkg::AccW:0]   rem_in,
    input  logic [lpp_pkg::AccW-1:0] den,
    input  logic                     bit_in,
    output logic [lpp_pkg::AccW:0]   rem_out,
    output logic                     q_bit
);
    import lpp_pkg::*;
    logic [AccW+1:0] trial;
    logic [AccW+1:0] shifted;

    always_comb
    begin
        shifted = {rem_in, bit_in};
        trial   = shifted - {2'b00, den};
        q_bit   = !trial[AccW+1];
        rem_out = q_bit ? trial[AccW:0] : shifted[AccW:0];
    end
endmodule

>>> rtl/lpp_pipe.sv
// Projection pipeline: gate, three MACs, 17 divider stages, rounding.
// Depends on lpp_pkg, lpp_div_stage and lidar_point_projection_top_assert.svh.
`include "lidar_point_projection_top_assert.svh"
module lpp_pipe (
    input  logic           clk,
    input  logic           rst_n,
    input  lpp_pkg::cfg_t  regs,
    input  logic           in_valid,
    input  lpp_pkg::point_t in_data,
    output logic           in_ready,
    output logic           out_valid,
    output lpp_pkg::pixel_t out_data,
    input  logic           out_ready
);
    import lpp_pkg::*;

    // numerator scaled: q = floor((2|n| + d) / 2d), computed on N=2|n|+d, D=2d

    logic [Stages-1:0] vld_reg;
    logic              adv;

    // per-stage payload
    logic signed [CoordW-1:0] x_reg [Stages];
    logic signed [CoordW-1:0] y_reg [Stages];
    logic signed [CoordW-1:0] z_reg [Stages];
    logic signed [AccW-1:0]   pu_reg [Stages];
    logic signed [AccW-1:0]   pv_reg [Stages];
    logic signed [AccW-1:0]   pw_reg [Stages];
    logic [AccW-1:0]          nu_reg [Stages];
    logic [AccW-1:0]          nv_reg [Stages];
    logic [AccW-1:0]          dd_reg [Stages];
    logic                     su_reg [Stages];
    logic                     sv_reg [Stages];
    logic                     bad_reg [Stages];
    logic [AccW:0]            ru_reg [Stages];
    logic [AccW:0]            rv_reg [Stages];
    logic [QuotW-1:0]         qu_reg [Stages];
    logic [QuotW-1:0]         qv_reg [Stages];
    logic [7:0]               red_reg [Stages];
    logic [7:0]               grn_reg [Stages];

    assign adv      = out_ready || !vld_reg[Stages-1];
    assign in_ready = adv;
    assign out_valid = vld_reg[Stages-1];

    // stage 0: window test
    logic signed [CoordW:0] ay;
    logic                   keep;

    function automatic logic signed [AccW-1:0] dot (
        input logic [CfgW-1:0]        row,
        input logic signed [CoordW-1:0] a,
        input logic signed [CoordW-1:0] b,
        input logic signed [CoordW-1:0] c,
        input logic signed [CoefW-1:0]  off
    );
        logic signed [AccW-1:0] s;
        s = AccW'($signed(row[CoefW-1:0]) * a)
          + AccW'($signed(row[2*CoefW-1:CoefW]) * b)
          + AccW'($signed(row[3*CoefW-1:2*CoefW]) * c)
          + AccW'(off);
        return s;
    endfunction

    always_comb
    begin
        ay   = in_data.point_y[CoordW-1] ? -{in_data.point_y[CoordW-1], in_data.point_y}
                                         : {1'b0, in_data.point_y};
        keep = (in_data.point_x >= XMinRaw)
            && ($signed({1'b0, in_data.point_x}) <= $signed({2'b00, regs.max_x}))
            && (ay <= $signed({2'b00, regs.max_y}))
            && (in_data.point_z >= regs.min_z);
    end

    // divide by 3840 = 256*15: drop 8 bits, then floor(a/15) = (a*4370) >> 16 for a < 4096
    function automatic logic [7:0] ramp (input logic [19:0] p);
        logic [24:0] t;
        t = 25'(p[19:8]) * 25'd4370;
        return t[23:16];
    endfunction

    // ramp levels from the stage 0 coordinate; at or beyond 15 m off centre they clamp
    logic [CoordW:0]   dx;
    logic [CoordW-1:0] adx;
    logic [7:0]        red_lvl;
    logic [7:0]        grn_lvl;

    always_comb
    begin
        dx  = {x_reg[0][CoordW-1], x_reg[0]} - (CoordW+1)'(RampCentre);
        adx = dx[CoordW] ? CoordW'(-dx) : CoordW'(dx);
        if (adx >= CoordW'(RampCentre))
        begin
            red_lvl = 8'd255;
            grn_lvl = 8'd0;
        end
        else
        begin
            red_lvl = ramp(20'(adx[11:0]) * 20'd255);
            grn_lvl = ramp(20'(12'(RampCentre) - adx[11:0]) * 20'd255);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[Stages-2:0], in_valid && keep};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0] <= in_data.point_x;
            y_reg[0] <= in_data.point_y;
            z_reg[0] <= in_data.point_z;
        end
    end

    // stage 1: sums of products, ramp levels
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[1] <= x_reg[0];
            y_reg[1] <= y_reg[0];
            red_reg[1] <= red_lvl;
            grn_reg[1] <= grn_lvl;
            pu_reg[1] <= dot(regs.row_u, x_reg[0], y_reg[0], z_reg[0],
                             regs.offset[CoefW-1:0]);
            pv_reg[1] <= dot(regs.row_v, x_reg[0], y_reg[0], z_reg[0],
                             regs.offset[2*CoefW-1:CoefW]);
            pw_reg[1] <= dot(regs.row_w, x_reg[0], y_reg[0], z_reg[0],
                             regs.offset[3*CoefW-1:2*CoefW]);
        end
    end

    // stage 2: magnitudes, signs, depth check, divider setup
    logic [AccW-1:0] mu, mv;
    always_comb
    begin
        mu = pu_reg[1][AccW-1] ? AccW'(-pu_reg[1]) : AccW'(pu_reg[1]);
        mv = pv_reg[1][AccW-1] ? AccW'(-pv_reg[1]) : AccW'(pv_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[2] <= x_reg[1];
            y_reg[2] <= y_reg[1];
            red_reg[2] <= red_reg[1];
            grn_reg[2] <= grn_reg[1];
            su_reg[2] <= pu_reg[1][AccW-1];
            sv_reg[2] <= pv_reg[1][AccW-1];
            bad_reg[2] <= (pw_reg[1] <= 0);
            // |n|/d rounded = floor((|n| + d/2)/d); quotient bits 16..0
            nu_reg[2] <= mu;
            nv_reg[2] <= mv;
            dd_reg[2] <= AccW'(pw_reg[1]);
            ru_reg[2] <= '0;
            rv_reg[2] <= '0;
            qu_reg[2] <= '0;
            qv_reg[2] <= '0;
        end
    end

    // stages 3..19: a range test (clamp), then one quotient bit of (2|n|+d)/(2d) each
    // Low bits of 2|n|+d are fed MSB first; quotient is saturated to QuotW bits.
    genvar g;
    generate
        for (g = 3; g < Stages; g++)
        begin : g_div
            logic [AccW:0] ru_n, rv_n;
            logic          qub, qvb;
            logic [AccW+1:0] numu, numv;
            if (g == 3)
            begin : g_first
                // remainder prefix: high part of N above QuotW-1 bits; saturate if N/D large
                logic [AccW+1:0] den2;
                logic [AccW+1:0] fu, fv;
                logic [AccW+1:0] hu, hv;
                assign den2 = {1'b0, dd_reg[g-1], 1'b0};
                assign fu = {1'b0, nu_reg[g-1], 1'b0} + {2'b00, dd_reg[g-1]};
                assign fv = {1'b0, nv_reg[g-1], 1'b0} + {2'b00, dd_reg[g-1]};
                assign hu = fu >> (QuotW - 1);
                assign hv = fv >> (QuotW - 1);
                assign numu = fu;
                assign numv = fv;
                assign qub = (hu >= den2);
                assign qvb = (hv >= den2);
                assign ru_n = '0;
                assign rv_n = '0;
            end
            else
            begin : g_rest
                localparam int B = Stages - 1 - g;
                logic [AccW-1:0] den;
                assign numu = '0;
                assign numv = '0;
                assign den  = {dd_reg[g-1][AccW-2:0], 1'b0};
                lpp_div_stage u_div_u (
                    .rem_in (ru_reg[g-1]),
                    .den    (den),
                    .bit_in (nu_reg[g-1][B]),
                    .rem_out(ru_n),
                    .q_bit  (qub)
                );
                lpp_div_stage u_div_v (
                    .rem_in (rv_reg[g-1]),
                    .den    (den),
                    .bit_in (nv_reg[g-1][B]),
                    .rem_out(rv_n),
                    .q_bit  (qvb)
                );
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    x_reg[g] <= x_reg[g-1];
                    y_reg[g] <= y_reg[g-1];
                    red_reg[g] <= red_reg[g-1];
                    grn_reg[g] <= grn_reg[g-1];
                    su_reg[g] <= su_reg[g-1];
                    sv_reg[g] <= sv_reg[g-1];
                    bad_reg[g] <= bad_reg[g-1];
                    dd_reg[g] <= dd_reg[g-1];
                    if (g == 3)
                    begin
                        // saturating overflow: mark quotient all ones
                        nu_reg[g] <= numu[AccW-1:0];
                        nv_reg[g] <= numv[AccW-1:0];
                        qu_reg[g] <= {QuotW{qub}};
                        qv_reg[g] <= {QuotW{qvb}};
                        ru_reg[g] <= qub ? '0 : (AccW+1)'(numu >> (QuotW-1));
                        rv_reg[g] <= qvb ? '0 : (AccW+1)'(numv >> (QuotW-1));
                    end
                    else
                    begin
                        nu_reg[g] <= nu_reg[g-1];
                        nv_reg[g] <= nv_reg[g-1];
                        ru_reg[g] <= ru_n;
                        rv_reg[g] <= rv_n;
                        qu_reg[g] <= qu_reg[g-1][QuotW-1] ? qu_reg[g-1]
                                   : {qu_reg[g-1][QuotW-2:0], qub};
                        qv_reg[g] <= qv_reg[g-1][QuotW-1] ? qv_reg[g-1]
                                   : {qv_reg[g-1][QuotW-2:0], qvb};
                    end
                end
            end
        end
    endgenerate

    // output stage: sign, saturation
    logic [QuotW-1:0] qu, qv;
    logic             satu, satv;
    always_comb
    begin
        qu = qu_reg[Stages-1];
        qv = qv_reg[Stages-1];
        satu = su_reg[Stages-1] ? (qu > 17'd32768) : (qu > 17'd32767);
        satv = sv_reg[Stages-1] ? (qv > 17'd32768) : (qv > 17'd32767);
        out_data.echo_x      = x_reg[Stages-1];
        out_data.echo_y      = y_reg[Stages-1];
        out_data.red_level   = red_reg[Stages-1];
        out_data.green_level = grn_reg[Stages-1];
        if (bad_reg[Stages-1])
        begin
            out_data.pixel_u = '0;
            out_data.pixel_v = '0;
            out_data.pixel_invalid = 1'b1;
        end
        else
        begin
            out_data.pixel_u = satu ? (su_reg[Stages-1] ? 16'sh8000 : 16'sh7fff)
                             : (su_reg[Stages-1] ? PixW'(-qu) : qu[PixW-1:0]);
            out_data.pixel_v = satv ? (sv_reg[Stages-1] ? 16'sh8000 : 16'sh7fff)
                             : (sv_reg[Stages-1] ? PixW'(-qv) : qv[PixW-1:0]);
            out_data.pixel_invalid = satu || satv;
        end
    end

    `LPP_ASSERT(a_stall_hold, (!adv |=> $stable(vld_reg)), "valid bits moved during stall")
    `LPP_ASSERT_NEXT(a_drop, (adv && !in_valid), !vld_reg[0], "bubble became an item")
    `LPP_ASSERT(a_ready, (in_ready == (out_ready || !out_valid)), "ready mismatch")
endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for lidar_point_projection_top: random and directed points,
// register phases, a scoreboard with its own projection predictor.
// Depends on lpp_pkg, lpp_if and the block's RTL.
module tb;
    import lpp_pkg::*;

    class projection_scoreboard;
        cfg_t   regs;
        pixel_t pending_pixels[$];
        int     errors;
        int     points_seen;
        int     pixels_seen;
        int     flagged_seen;

        function void clear_regs();
            regs = '0;
            regs.max_x = 23'h7FFFFF;
            regs.max_y = 23'h7FFFFF;
            regs.min_z = 24'sh800000;
        endfunction

        function void note_reg(logic [2:0] idx, logic [63:0] value);
            case (idx)
                REG_ROW_U:  regs.row_u = value[62:0];
                REG_ROW_V:  regs.row_v = value[62:0];
                REG_ROW_W:  regs.row_w = value[62:0];
                REG_OFFSET: regs.offset = value[62:0];
                REG_MAX_X:  regs.max_x = value[22:0];
                REG_MAX_Y:  regs.max_y = value[22:0];
                REG_MIN_Z:  regs.min_z = value[23:0];
                default: ;
            endcase
        endfunction

        function longint coef(logic [62:0] word, int slot);
            logic signed [20:0] c;
            c = word[21*slot +: 21];
            return longint'(c);
        endfunction

        function longint row_sum(logic [62:0] row, longint x, longint y, longint z, int slot);
            return coef(row, 0) * x + coef(row, 1) * y + coef(row, 2) * z
                + coef(regs.offset, slot);
        endfunction

        function logic signed [15:0] divide_round(longint num, longint den, ref logic sat);
            longint unsigned mag;
            longint unsigned q;
            longint r;
            mag = num < 0 ? -num : num;
            q = (2 * mag + den) / (2 * den);
            if (q > 40000) q = 40000;
            r = num < 0 ? -longint'(q) : longint'(q);
            if (r > 32767)
            begin
                r = 32767;
                sat = 1'b1;
            end
            if (r < -32768)
            begin
                r = -32768;
                sat = 1'b1;
            end
            return r[15:0];
        endfunction

        function void note_point(point_t p);
            longint x, y, z, ay, u, v, w, d, red;
            pixel_t px;
            logic   sat;
            x = longint'(p.point_x);
            y = longint'(p.point_y);
            z = longint'(p.point_z);
            ay = y < 0 ? -y : y;
            points_seen++;
            if (x < 52 || x > longint'(regs.max_x) || ay > longint'(regs.max_y)
                || z < longint'(regs.min_z))
                return;
            u = row_sum(regs.row_u, x, y, z, 0);
            v = row_sum(regs.row_v, x, y, z, 1);
            w = row_sum(regs.row_w, x, y, z, 2);
            px = '0;
            sat = 1'b0;
            if (w <= 0)
            begin
                sat = 1'b1;
            end
            else
            begin
                px.pixel_u = divide_round(u, w, sat);
                px.pixel_v = divide_round(v, w, sat);
            end
            px.pixel_invalid = sat;
            px.echo_x = p.point_x;
            px.echo_y = p.point_y;
            d = x - 3840;
            if (d < 0) d = -d;
            red = (255 * d) / 3840;
            px.red_level = red > 255 ? 8'd255 : red[7:0];
            px.green_level = d >= 3840 ? 8'd0 : 8'((255 * (3840 - d)) / 3840);
            pending_pixels = {pending_pixels, px};
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            pixels_seen++;
            if (got.pixel_invalid) flagged_seen++;
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel beat %h", $time, got);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if (got.pixel_u !== want.pixel_u)
            begin
                $display("%0t: pixel_u exp %0d got %0d", $time, want.pixel_u, got.pixel_u);
                errors++;
            end
            if (got.pixel_v !== want.pixel_v)
            begin
                $display("%0t: pixel_v exp %0d got %0d", $time, want.pixel_v, got.pixel_v);
                errors++;
            end
            if (got.pixel_invalid !== want.pixel_invalid)
            begin
                $display("%0t: pixel_invalid exp %0d got %0d", $time,
                    want.pixel_invalid, got.pixel_invalid);
                errors++;
            end
            if (got.echo_x !== want.echo_x)
            begin
                $display("%0t: echo_x exp %0d got %0d", $time, want.echo_x, got.echo_x);
                errors++;
            end
            if (got.echo_y !== want.echo_y)
            begin
                $display("%0t: echo_y exp %0d got %0d", $time, want.echo_y, got.echo_y);
                errors++;
            end
            if (got.red_level !== want.red_level)
            begin
                $display("%0t: red_level exp %0d got %0d", $time,
                    want.red_level, got.red_level);
                errors++;
            end
            if (got.green_level !== want.green_level)
            begin
                $display("%0t: green_level exp %0d got %0d", $time,
                    want.green_level, got.green_level);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    lpp_point_if points();
    lpp_pixel_if pixels();
    lpp_cfg_if   cfg();

    lidar_point_projection_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (points.sink),
        .pixels (pixels.source),
        .cfg    (cfg.sink)
    );

    projection_scoreboard sb;
    int  idle_cycles;
    int  hold_off;
    bit  sender_gaps;
    bit  receiver_stalls;
    int  phases_run;

    localparam int WatchdogLimit = 20000;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
                sb.note_reg(cfg.index, cfg.wdata);
            if (points.valid && points.ready)
                sb.note_point(points.data);
            if (pixels.valid && pixels.ready)
                sb.check_pixel(pixels.data);
            if ((cfg.valid && cfg.ready) || (points.valid && points.ready)
                || (pixels.valid && pixels.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("Watchdog expired with %0d pixels outstanding",
                sb.pending_pixels.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // pixel sink: random per-beat stalls plus an occasional long hold-off
    initial
    begin
        int stall;
        stall = 0;
        pixels.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pixels.valid && pixels.ready)
                stall = receiver_stalls ? $urandom_range(0, 9) : 0;
            if (hold_off > 0)
            begin
                hold_off--;
                pixels.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                pixels.ready <= 1'b0;
            end
            else
            begin
                pixels.ready <= rst_n;
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.wdata <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending_pixels.size() != 0) @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic send_point(point_t p);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            points.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        points.valid <= 1'b1;
        points.data <= p;
        @(posedge clk);
        while (!points.ready) @(posedge clk);
    endtask

    task automatic end_burst();
        points.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] pack_row(int a, int b, int c);
        logic [20:0] fa, fb, fc;
        fa = a[20:0];
        fb = b[20:0];
        fc = c[20:0];
        return {1'($urandom_range(0, 1)), fc, fb, fa};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic int rand_coef(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic point_t make_point(int x, int y, int z);
        point_t p;
        p.point_x = x[23:0];
        p.point_y = y[23:0];
        p.point_z = z[23:0];
        return p;
    endfunction

    function automatic point_t random_point();
        point_t p;
        int mx, my, mz, x;
        mx = int'(sb.regs.max_x);
        my = int'(sb.regs.max_y);
        mz = int'(sb.regs.min_z);
        if ($urandom_range(0, 4) == 0 || mx < 52)
        begin
            p = {24'($urandom()), 24'($urandom()), 24'($urandom())};
            return p;
        end
        if ($urandom_range(0, 1) == 0)
            x = $urandom_range(52, mx < 9000 ? mx : 9000);
        else
            x = $urandom_range(52, mx);
        p.point_x = x[23:0];
        p.point_y = 24'($urandom_range(0, 2 * my) - my);
        p.point_z = 24'($urandom_range(mz + 8388608, 16777215) - 8388608);
        return p;
    endfunction

    // camera-like matrix: depth grows with x, small lateral terms
    task automatic camera_regs(int mx, int my, int mz);
        write_reg(REG_ROW_U, pack_row(rand_coef(4000), rand_coef(600000), rand_coef(20000)));
        write_reg(REG_ROW_V, pack_row(rand_coef(4000), rand_coef(20000), rand_coef(600000)));
        write_reg(REG_ROW_W, pack_row($urandom_range(200, 1100), rand_coef(30), rand_coef(30)));
        write_reg(REG_OFFSET, pack_row(rand_coef(1048575), rand_coef(1048575),
            rand_coef(1048575)));
        write_reg(REG_MAX_X, {$urandom(), 9'($urandom())} & 64'hFFFFFFFFFF800000 | mx);
        write_reg(REG_MAX_Y, {$urandom(), 9'($urandom())} & 64'hFFFFFFFFFF800000 | my);
        write_reg(REG_MIN_Z, {$urandom(), 8'($urandom()), 24'(mz)});
    endtask

    task automatic random_burst(int n);
        repeat (n) send_point(random_point());
        end_burst();
    endtask

    initial
    begin
        point_t burst[$];
        sb = new();
        sb.clear_regs();
        idle_cycles = 0;
        hold_off = 0;
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        phases_run = 0;
        rst_n = 1'b0;
        points.valid = 1'b0;
        points.data = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_NONE;
        cfg.wdata = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: zero depth everywhere
        send_point(make_point(52, -8388607, -8388608));
        send_point(make_point(8388607, 8388607, 8388607));
        send_point(make_point(51, 0, 0));
        send_point(make_point(3840, -8388608, 0));
        end_burst();
        drain();

        // directed: limits, ramp, saturation, negative depth, ignored register
        write_reg(REG_ROW_U, pack_row(1048575, -1048576, 7));
        write_reg(REG_ROW_V, pack_row(-1048576, 3, 1048575));
        write_reg(REG_ROW_W, pack_row(1, 0, -1));
        write_reg(REG_OFFSET, pack_row(-1048576, 1048575, 0));
        write_reg(REG_MAX_X, 64'd8000);
        write_reg(REG_MAX_Y, 64'd2000);
        write_reg(REG_MIN_Z, 64'hFFFF_FFFF_FFFF_FC00);
        write_reg(REG_NONE, rand64());
        burst = {make_point(51, 0, 0), make_point(52, 0, 0), make_point(8000, 0, 0),
                 make_point(8001, 0, 0), make_point(100, 2000, -1024),
                 make_point(100, -2000, -1024), make_point(100, 2001, 0),
                 make_point(100, -8388608, 0), make_point(100, 0, -1025),
                 make_point(3840, 5, 5), make_point(7680, 5, 5), make_point(7679, 0, 0),
                 make_point(200, 0, 200), make_point(200, 0, 300),
                 make_point(60, 1, 59), make_point(1000, -1000, 8388607)};
        foreach (burst[i]) send_point(burst[i]);
        end_burst();
        drain();

        // camera-like settings, all gaps
        camera_regs(12800, 5120, -512);
        random_burst(120);
        drain();
        phases_run++;

        // full back-to-back with a long sink hold-off to fill the pipeline
        camera_regs(8388607, 8388607, -8388608);
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        hold_off = 300;
        random_burst(120);
        drain();
        phases_run++;

        // random coefficients at the extremes of the register ranges
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        write_reg(REG_ROW_U, rand64());
        write_reg(REG_ROW_V, rand64());
        write_reg(REG_ROW_W, rand64());
        write_reg(REG_OFFSET, rand64());
        write_reg(REG_MAX_X, 64'h7FFFFF);
        write_reg(REG_MAX_Y, 64'h7FFFFF);
        write_reg(REG_MIN_Z, 64'h800000);
        random_burst(100);
        drain();
        phases_run++;

        // tight window: max_y zero, min_z at its top
        camera_regs(3000, 0, 8388607);
        send_point(make_point(52, 0, 8388607));
        send_point(make_point(52, 1, 8388607));
        send_point(make_point(52, 0, 8388606));
        random_burst(40);
        drain();
        write_reg(REG_MAX_X, 64'd0);
        random_burst(20);
        drain();
        phases_run++;

        // mixed idling, camera settings again
        camera_regs(25600, 2560, -2560);
        sender_gaps = 1'b0;
        random_burst(60);
        sender_gaps = 1'b1;
        receiver_stalls = 1'b0;
        random_burst(60);
        receiver_stalls = 1'b1;
        drain();
        phases_run++;

        $display("Sent %0d points over %0d register phases, %0d pixels checked (%0d flagged).",
            sb.points_seen, phases_run + 2, sb.pixels_seen, sb.flagged_seen);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/lpp_pkg.sv
rtl/lpp_if.sv
rtl/lpp_regs.sv
rtl/lpp_divider.sv
rtl/lpp_pipe.sv
rtl/lidar_point_projection_top.sv
tb/sv/tb.sv
